// ----- rtl/slotp_pkg.sv -----
package slotp_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 1024;

  localparam int unsigned LIFE_W  = 24;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned LIVE_W  = 11;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

endpackage

// ----- rtl/slot_pool_with_lifetime_expiry.sv -----
// Slot pool with lifetime expiry.
//
// Input requests arrive on in_*: in_tuser is the kind (0 = spawn, 1 = tick),
// in_tdata carries the birth lifetime and the time step, both Q8.16.
// Every request yields exactly one result on out_*: granted flag, slot index
// and live count packed into out_tdata.
// A spawn passes through S_POP, which pops the free stack and writes the slot's
// lifetime, and then S_DONE, which loads the result into the output register; a
// spawn on an empty stack goes straight to S_DONE. A tick runs the S_TICK sweep,
// which reads one lifetime entry per cycle and writes it back in the next cycle,
// pushing expired slots onto the free stack, then goes to S_DONE to load the
// result. One request is worked on at a time; in_tready is high only while idle,
// so the next request is accepted only after the current one's result is loaded.
// A result waiting in the output register does not block acceptance of the next
// request; if the receiver stalls, the finished result of that next request is
// held until the output register frees up.
// Reset empties the pool with no clearing pass: a low-water mark on the free
// stack tells which stack entries and which slots were never handed out, and
// those read as their reset contents.
module slot_pool_with_lifetime_expiry #(
  parameter int unsigned SLOT_COUNT = slotp_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [23:0] birth_life, [47:24] time_step
  input  logic [slotp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] granted, [10:1] slot_index, [21:11] live_count, [23:22] zero
  output logic [slotp_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LIFE_W = slotp_pkg::LIFE_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_TICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        depth_r, depth_nxt;
  logic [CNT_W-1:0]        low_r, low_nxt;
  logic [CNT_W-1:0]        touched_r, touched_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    tick_rd_r, tick_rd_nxt;
  logic [IDX_W-1:0]        tick_idx_r, tick_idx_nxt;
  logic [LIFE_W-1:0]       dt_r, dt_nxt;
  logic [LIFE_W-1:0]       birth_r, birth_nxt;
  logic [CNT_W-1:0]        live_r, live_nxt;
  logic                    granted_r, granted_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [slotp_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                    in_fire;
  logic [CNT_W-1:0]        pop_pos;
  logic                    pop_first;
  logic [IDX_W-1:0]        pop_slot;

  logic                    life_we;
  logic [IDX_W-1:0]        life_waddr;
  logic [LIFE_W:0]         life_wdata;
  logic [LIFE_W:0]         life_rdata;
  logic                    stack_we;
  logic [IDX_W-1:0]        stack_waddr;
  logic [IDX_W-1:0]        stack_wdata;
  logic [IDX_W-1:0]        stack_rdata;

  logic                    slot_in_use;
  logic                    slot_expires;
  logic [31:0]             live_wide;
  logic [31:0]             slot_wide;

  // Lifetime memory: bit LIFE_W is the alive flag, the rest the lifetime.
  slotp_ram #(
    .WIDTH (LIFE_W + 1),
    .DEPTH (SLOT_COUNT)
  ) u_life_ram (
    .clk   (clk),
    .we    (life_we),
    .waddr (life_waddr),
    .wdata (life_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (life_rdata)
  );

  slotp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (pop_pos[IDX_W-1:0]),
    .rdata (stack_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Stack positions below the low-water mark have never been popped, so they
  // still hold their reset contents and the memory entry is not consulted.
  assign pop_pos   = depth_r - CNT_W'(1);
  assign pop_first = (pop_pos < low_r);
  assign pop_slot  = pop_first ? (IDX_LAST - pop_pos[IDX_W-1:0]) : stack_rdata;

  // A slot is only alive if it was handed out at least once; slots numbered
  // from touched_r upward were never written and read as dead.
  assign slot_in_use  = life_rdata[LIFE_W] && (CNT_W'(tick_idx_r) < touched_r);
  assign slot_expires = (life_rdata[LIFE_W-1:0] <= dt_r);

  assign live_wide = 32'(live_r);
  assign slot_wide = 32'(slot_r);

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    low_nxt       = low_r;
    touched_nxt   = touched_r;
    cnt_nxt       = cnt_r;
    tick_rd_nxt   = tick_rd_r;
    tick_idx_nxt  = tick_idx_r;
    dt_nxt        = dt_r;
    birth_nxt     = birth_r;
    live_nxt      = live_r;
    granted_nxt   = granted_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    life_we     = 1'b0;
    life_waddr  = tick_idx_r;
    life_wdata  = {1'b0, life_rdata[LIFE_W-1:0]};
    stack_we    = 1'b0;
    stack_waddr = depth_r[IDX_W-1:0];
    stack_wdata = tick_idx_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          granted_nxt = 1'b0;
          slot_nxt    = '0;
          live_nxt    = '0;
          birth_nxt   = in_tdata[LIFE_W-1:0];
          dt_nxt      = in_tdata[2*LIFE_W-1:LIFE_W];
          if (in_tuser == slotp_pkg::KIND_TICK) begin
            cnt_nxt     = '0;
            tick_rd_nxt = 1'b0;
            state_nxt   = S_TICK;
          end else if (depth_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        life_we     = 1'b1;
        life_waddr  = pop_slot;
        life_wdata  = {1'b1, birth_r};
        depth_nxt   = pop_pos;
        if (pop_first) begin
          low_nxt     = pop_pos;
          touched_nxt = touched_r + CNT_W'(1);
        end
        granted_nxt = 1'b1;
        slot_nxt    = pop_slot;
        state_nxt   = S_DONE;
      end
      S_TICK: begin
        if (tick_rd_r && slot_in_use) begin
          life_we = 1'b1;
          if (slot_expires) begin
            life_wdata = {1'b0, life_rdata[LIFE_W-1:0]};
            if (depth_r < CNT_FULL) begin
              stack_we  = 1'b1;
              depth_nxt = depth_r + CNT_W'(1);
            end
          end else begin
            life_wdata = {1'b1, life_rdata[LIFE_W-1:0] - dt_r};
            live_nxt   = live_r + CNT_W'(1);
          end
        end
        tick_rd_nxt  = (cnt_r != CNT_FULL);
        tick_idx_nxt = cnt_r[IDX_W-1:0];
        if (cnt_r != CNT_FULL) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!tick_rd_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, live_wide[slotp_pkg::LIVE_W-1:0],
                           slot_wide[slotp_pkg::INDEX_W-1:0], granted_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= CNT_FULL;
      low_r       <= CNT_FULL;
      touched_r   <= '0;
      cnt_r       <= '0;
      tick_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      low_r       <= low_nxt;
      touched_r   <= touched_nxt;
      cnt_r       <= cnt_nxt;
      tick_rd_r   <= tick_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_idx_r <= tick_idx_nxt;
    dt_r       <= dt_nxt;
    birth_r    <= birth_nxt;
    live_r     <= live_nxt;
    granted_r  <= granted_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/slotp_ram.sv -----
module slotp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- test/tb_slot_pool_with_lifetime_expiry.sv -----
module tb_slot_pool_with_lifetime_expiry;

  localparam int unsigned SLOTS           = slotp_pkg::SLOT_COUNT_DEF;
  localparam int unsigned LIFE_W          = slotp_pkg::LIFE_W;
  localparam int unsigned INDEX_W         = slotp_pkg::INDEX_W;
  localparam int unsigned LIVE_W          = slotp_pkg::LIVE_W;
  localparam int unsigned IN_DATA_W       = slotp_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W      = slotp_pkg::OUT_DATA_W;
  localparam int unsigned HOLD_OFF_CYCLES = 2500;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES    = SLOTS + 16;

  typedef struct packed {
    logic               granted;
    logic [INDEX_W-1:0] slot_index;
    logic [LIVE_W-1:0]  live_count;
  } pool_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = slotp_pkg::KIND_SPAWN;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Expected-side copy of the pool.
  logic [LIFE_W-1:0] life_left [SLOTS];
  logic              slot_live [SLOTS];
  int unsigned       free_slots [SLOTS];
  int unsigned       free_top;
  pool_result_t      pending_results [$];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  logic        hold_active   = 1'b0;
  event        hold_off_ev;
  pool_result_t want;

  slot_pool_with_lifetime_expiry #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_pool_model();
    for (int unsigned k = 0; k < SLOTS; k++) begin
      life_left[k]  = '0;
      slot_live[k]  = 1'b0;
      free_slots[k] = SLOTS - 1 - k;
    end
    free_top = SLOTS;
  endfunction

  // Applies one request to the pool copy and queues the result it must produce.
  function automatic void apply_pool_request(input logic kind, input logic [LIFE_W-1:0] life,
                                             input logic [LIFE_W-1:0] step);
    pool_result_t res;
    int unsigned  slot;
    int unsigned  live;
    res  = '0;
    live = 0;
    if (kind == slotp_pkg::KIND_SPAWN) begin
      if (free_top != 0) begin
        free_top--;
        slot            = free_slots[free_top];
        slot_live[slot] = 1'b1;
        life_left[slot] = life;
        res.granted     = 1'b1;
        res.slot_index  = INDEX_W'(slot);
      end
    end else begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (slot_live[i]) begin
          // The signed difference is zero or negative exactly when life <= step.
          if (life_left[i] <= step) begin
            slot_live[i] = 1'b0;
            if (free_top < SLOTS) begin
              free_slots[free_top] = i;
              free_top++;
            end
          end else begin
            life_left[i] = life_left[i] - step;
            live++;
          end
        end
      end
      res.live_count = LIVE_W'(live);
    end
    pending_results.push_back(res);
  endfunction

  task automatic send_request(input logic kind, input logic [LIFE_W-1:0] life,
                              input logic [LIFE_W-1:0] step);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 1'($urandom);
      in_tdata  <= IN_DATA_W'({$urandom, $urandom});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {step, life};
    do @(posedge clk); while (in_tready !== 1'b1);
    apply_pool_request(kind, life, step);
  endtask

  function automatic logic [LIFE_W-1:0] pick_life();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return '1;
    if (sel < 22) return LIFE_W'($urandom);
    return LIFE_W'($urandom_range(24'h0FFFFF));
  endfunction

  function automatic logic [LIFE_W-1:0] pick_step();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) return '0;
    if (sel < 9) return '1;
    if (sel < 19) return LIFE_W'($urandom);
    return LIFE_W'($urandom_range(24'h03FFFF));
  endfunction

  task automatic test_directed();
    send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), '0);
    send_request(slotp_pkg::KIND_SPAWN, '1, '1);
    send_request(slotp_pkg::KIND_SPAWN, '0, LIFE_W'($urandom));
    send_request(slotp_pkg::KIND_SPAWN, LIFE_W'(1), '0);
    send_request(slotp_pkg::KIND_SPAWN, LIFE_W'(24'h010000), '1);
    // A zero step keeps every positive lifetime but retires the zero-lifetime slot.
    send_request(slotp_pkg::KIND_TICK, '1, '0);
    send_request(slotp_pkg::KIND_SPAWN, LIFE_W'(5), '0);
    send_request(slotp_pkg::KIND_TICK, '0, LIFE_W'(1));
    send_request(slotp_pkg::KIND_TICK, '0, '1);
    send_request(slotp_pkg::KIND_SPAWN, '1, '0);
    send_request(slotp_pkg::KIND_SPAWN, LIFE_W'(24'h800000), '1);
    send_request(slotp_pkg::KIND_TICK, '1, LIFE_W'(24'hFFFFFE));
    // The survivor is left with exactly one LSB, so a step of one hits zero.
    send_request(slotp_pkg::KIND_TICK, '1, LIFE_W'(1));
    send_request(slotp_pkg::KIND_TICK, '1, '0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(99) < 68) begin
        send_request(slotp_pkg::KIND_SPAWN, pick_life(), LIFE_W'($urandom));
      end else begin
        send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), pick_step());
      end
    end
  endtask

  task automatic test_result_stall();
    -> hold_off_ev;
    send_request(slotp_pkg::KIND_SPAWN, pick_life(), LIFE_W'($urandom));
    send_request(slotp_pkg::KIND_SPAWN, pick_life(), LIFE_W'($urandom));
    send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), pick_step());
    repeat (5) send_request(slotp_pkg::KIND_SPAWN, pick_life(), LIFE_W'($urandom));
  endtask

  task automatic test_spawn_burst();
    send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), '1);
    repeat (40) begin
      send_request(slotp_pkg::KIND_SPAWN, LIFE_W'($urandom_range(1, 24'hFFFFFF)),
                   LIFE_W'($urandom));
    end
    // Every live slot has a positive lifetime, so a zero step keeps them all.
    send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), '0);
    send_request(slotp_pkg::KIND_SPAWN, pick_life(), LIFE_W'($urandom));
    send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), LIFE_W'(24'h400000));
    repeat (12) send_request(slotp_pkg::KIND_SPAWN, pick_life(), LIFE_W'($urandom));
    send_request(slotp_pkg::KIND_TICK, LIFE_W'($urandom), '1);
  endtask

  task automatic finish_run();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  always begin
    @(hold_off_ev);
    hold_active <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result 0x%h arrived with no request outstanding", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[INDEX_W:1] !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index,
                 out_tdata[INDEX_W:1]);
          fail_count++;
        end
        if (out_tdata[INDEX_W+LIVE_W:INDEX_W+1] !== want.live_count) begin
          $error("live_count: expected %0d, actual %0d", want.live_count,
                 out_tdata[INDEX_W+LIVE_W:INDEX_W+1]);
          fail_count++;
        end
        if (out_tdata[OUT_DATA_W-1:INDEX_W+LIVE_W+1] !== '0) begin
          $error("pad: expected 0, actual %0d", out_tdata[OUT_DATA_W-1:INDEX_W+LIVE_W+1]);
          fail_count++;
        end
      end
    end
    out_tready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    reset_pool_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 35;
    sink_idle_pct = 59;
    test_directed();
    test_random_traffic(170);

    src_idle_pct  = 59;
    sink_idle_pct = 35;
    test_result_stall();
    test_random_traffic(170);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_spawn_burst();
    test_random_traffic(160);

    finish_run();
  end

endmodule

// ----- files.f -----
rtl/slotp_pkg.sv
rtl/slotp_ram.sv
rtl/slot_pool_with_lifetime_expiry.sv
test/tb_slot_pool_with_lifetime_expiry.sv
